[hw/rtl/npcs_pkg.sv]
// Package for the nearest palette color search core: widths, codes, link types.
// Used by npcs_cell and nearest_palette_color_search_core; depends on nothing.
package npcs_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int IDX_W               = 8;
  localparam int CHAN_W              = 8;
  localparam int DIST_W              = 10;

  // Largest possible Manhattan distance, 255 * 3.
  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(255 * 3);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  // Palette write broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    color_t           color;
  } wr_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } link_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

  function automatic logic [DIST_W-1:0] color_dist(input color_t a, input color_t b);
    logic [DIST_W-1:0] d;
    d = DIST_W'(abs_diff(a.red, b.red)) + DIST_W'(abs_diff(a.green, b.green))
      + DIST_W'(abs_diff(a.blue, b.blue));
    return d;
  endfunction

endpackage

[hw/rtl/npcs_cell.sv]
// One search cell: holds one palette entry and updates the passing token.
// Depends on npcs_pkg.
module npcs_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  npcs_pkg::wr_t   wr,
  input  npcs_pkg::color_t pixel,
  input  npcs_pkg::link_t link_in,
  output npcs_pkg::link_t link_out
);
  import npcs_pkg::*;

  localparam logic [IDX_W-1:0] CellIdx = IDX_W'(CELL_INDEX);

  color_t            entry_r;
  link_t             link_r;
  link_t             link_nxt;
  logic [DIST_W-1:0] cell_dist;

  // Capture the entry on a write addressed to this cell.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.index == CellIdx)) begin
      entry_r <= wr.color;
    end
  end

  assign cell_dist = color_dist(entry_r, pixel);

  // Replace the best only on a strictly smaller distance: lowest index wins ties.
  always_comb begin
    link_nxt = link_in;
    if (link_in.valid && (cell_dist < link_in.best_dist)) begin
      link_nxt.best_dist = cell_dist;
      link_nxt.best_idx  = CellIdx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else begin
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;

endmodule

[hw/rtl/nearest_palette_color_search_core.sv]
// Top level of the nearest palette color search core: control, cell chain, output word.
// Depends on npcs_pkg and npcs_cell.
//
//   channel | direction | ports                                        | handshake
//   --------+-----------+----------------------------------------------+---------------
//   in      | input     | in_func in_entry_index in_red in_green in_blue | in_valid/in_stall
//   out     | output    | out_best_index out_exact_match               | out_valid/out_stall
//
// A palette write is taken as soon as it is accepted; the next word can follow at once.
// When out_stall stays low, a query passes from acceptance through the launch
// register, every cell of the chain in turn and the output word before the next acceptance.
// Only one query is in flight; in_stall is high from its acceptance until its
// result word leaves, so out_stall holds back the input side too.
// Reset (rst_n low, synchronous) clears control and the chain tokens; the palette
// cells have no reset and must be written before a query reads them.
module nearest_palette_color_search_core #(
  parameter int PALETTE_ENTRIES = npcs_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [npcs_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [npcs_pkg::CHAN_W-1:0] in_red,
  input  logic [npcs_pkg::CHAN_W-1:0] in_green,
  input  logic [npcs_pkg::CHAN_W-1:0] in_blue,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [npcs_pkg::IDX_W-1:0]  out_best_index,
  output logic                        out_exact_match
);
  import npcs_pkg::*;

  logic                 busy_r;
  logic                 busy_nxt;
  logic                 start_r;
  color_t               pixel_r;
  wr_t                  wr;
  logic                 in_acc;
  logic                 query_acc;
  logic                 out_acc;
  link_t                chain [PALETTE_ENTRIES+1];
  logic [PALETTE_ENTRIES-1:0] tok_valid;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_exact_r;

  // Hold off new words while a query is in the chain or its result waits.
  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !busy_r;
  assign query_acc = in_acc && (in_func == FUNC_QUERY);
  assign out_acc   = out_valid_r && !out_stall;

  // Broadcast palette writes straight to the cells; no cell matches an index
  // at or beyond the palette size, so such a write is dropped.
  always_comb begin
    wr.en          = in_acc && (in_func == FUNC_WRITE);
    wr.index       = in_entry_index;
    wr.color.red   = in_red;
    wr.color.green = in_green;
    wr.color.blue  = in_blue;
  end

  // Latch the query pixel; it stays stable for the whole scan.
  always_ff @(posedge clk) begin
    if (query_acc) begin
      pixel_r.red   <= in_red;
      pixel_r.green <= in_green;
      pixel_r.blue  <= in_blue;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (query_acc) begin
      busy_nxt = 1'b1;
    end else if (out_acc) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      start_r <= query_acc;
    end
  end

  // Launch the token at the head of the chain with the worst distance and index 0,
  // which is also the answer when every entry sits at the maximum distance.
  always_comb begin
    chain[0].valid     = start_r;
    chain[0].best_dist = MAX_DIST;
    chain[0].best_idx  = '0;
  end

  // Advance the token one cell per cycle, entry 0 first.
  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    npcs_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .pixel   (pixel_r),
      .link_in (chain[g]),
      .link_out(chain[g+1])
    );
    assign tok_valid[g] = chain[g+1].valid;
  end

  // Output word: load from the chain tail, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (chain[PALETTE_ENTRIES].valid) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain[PALETTE_ENTRIES].valid) begin
      out_idx_r   <= chain[PALETTE_ENTRIES].best_idx;
      out_exact_r <= (chain[PALETTE_ENTRIES].best_dist == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_index  = out_idx_r;
  assign out_exact_match = out_exact_r;

  // A waiting result belongs to the query that keeps the block busy.
  a_out_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r)
    else $error("result word present while block not busy");

  // Never more than one token travels the chain.
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_valid, start_r}))
    else $error("more than one search token in the chain");

  // A token reaching the tail never lands on a result still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    chain[PALETTE_ENTRIES].valid |-> !out_valid_r)
    else $error("search result overwrote a waiting word");

  // A query start launches a token in the next cycle.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> (start_r && busy_r))
    else $error("accepted query did not launch");

endmodule
